// ----- hw/rtl/mric_pkg.sv -----
`default_nettype none

package mric_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned InDataWidth = 32;
  localparam int unsigned OutDataWidth = 72;

  typedef enum logic [2:0] {
    CLS_LEGAL  = 3'd0,
    CLS_REG    = 3'd1,
    CLS_IMM    = 3'd2,
    CLS_BRANCH = 3'd3,
    CLS_LS     = 3'd4,
    CLS_R4K    = 3'd5,
    CLS_COP    = 3'd6,
    CLS_UNK    = 3'd7
  } cls_e;

  // Opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_COP0    = 6'd16;

  // Opcode groups taken from the top three opcode bits.
  localparam logic [2:0] GRP_BRANCH = 3'd0;
  localparam logic [2:0] GRP_IMM    = 3'd1;
  localparam logic [2:0] GRP_UNK    = 3'd3;
  localparam logic [2:0] GRP_LOAD   = 3'd4;
  localparam logic [2:0] GRP_STORE  = 3'd5;

  // Register group function codes.
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_BREAK   = 6'd13;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  // REGIMM rt codes.
  localparam logic [4:0] RT_BLTZ   = 5'd0;
  localparam logic [4:0] RT_BGEZ   = 5'd1;
  localparam logic [4:0] RT_BLTZAL = 5'd16;
  localparam logic [4:0] RT_BGEZAL = 5'd17;

  // CP0 rs codes and CO function codes.
  localparam logic [4:0] RS_MF = 5'd0;
  localparam logic [4:0] RS_MT = 5'd4;
  localparam logic [4:0] RS_BC = 5'd8;
  localparam logic [4:0] RS_CO = 5'd16;
  localparam logic [5:0] CO_TLBR  = 6'd1;
  localparam logic [5:0] CO_TLBWI = 6'd2;
  localparam logic [5:0] CO_TLBWR = 6'd6;
  localparam logic [5:0] CO_TLBP  = 6'd8;
  localparam logic [5:0] CO_RFE   = 6'd16;
  localparam logic [5:0] CO_WAIT  = 6'd32;
  localparam logic [4:0] RD_CONTEXT = 5'd4;

  // Mnemonic codes of the CP0 group and the nop form.
  localparam logic [5:0] MN_MFC0   = 6'd0;
  localparam logic [5:0] MN_BC0F   = 6'd3;
  localparam logic [5:0] MN_MTC0   = 6'd4;
  localparam logic [5:0] MN_BC0T   = 6'd5;
  localparam logic [5:0] MN_RFE    = 6'd7;
  localparam logic [5:0] MN_WAIT   = 6'd9;
  localparam logic [5:0] MN_TLBCLR = 6'd10;
  localparam logic [5:0] MN_NOP    = 6'd62;

  localparam logic [3:0]  CP0_PRID_IDX   = 4'd8;
  localparam logic [15:0] CP0_VALID_MASK = 16'hF507;
  localparam logic [63:0] LS_VALID_MASK  = 64'h0000_4F7F_0000_0000;

  typedef struct packed {
    logic [1:0]         coprocessor_number;
    logic [3:0]         cp0_register;
    logic signed [31:0] operand_value;
    logic [4:0]         shift_amount;
    logic [4:0]         target_register;
    logic [4:0]         source_register;
    logic [4:0]         dest_register;
    cls_e               illegal_class;
    logic [5:0]         mnemonic_code;
  } result_t;

  function automatic logic [3:0] cp0_rd_to_idx(input logic [3:0] rd);
    logic [3:0] idx;
    case (rd)
      4'd0:    idx = 4'd0;
      4'd1:    idx = 4'd1;
      4'd2:    idx = 4'd2;
      4'd8:    idx = 4'd3;
      4'd10:   idx = 4'd4;
      4'd12:   idx = 4'd5;
      4'd13:   idx = 4'd6;
      4'd14:   idx = 4'd7;
      default: idx = CP0_PRID_IDX;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mric_decode.sv -----
`default_nettype none

module mric_decode (
  input  logic [mric_pkg::WordWidth-1:0] word_i,
  output mric_pkg::result_t              result_o
);

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [31:0] zext;
  logic [31:0] sext;
  logic [31:0] boff;
  logic        cp0_valid;
  logic        reg_bad;
  logic [5:0]  code;
  logic [31:0] opv;
  mric_pkg::cls_e cls;

  assign op   = word_i[31:26];
  assign rs   = word_i[25:21];
  assign rt   = word_i[20:16];
  assign rd   = word_i[15:11];
  assign sh   = word_i[10:6];
  assign fn   = word_i[5:0];
  assign zext = {16'd0, word_i[15:0]};
  assign sext = {{16{word_i[15]}}, word_i[15:0]};
  assign boff = {sext[29:0], 2'b00};
  assign cp0_valid = !rd[4] && mric_pkg::CP0_VALID_MASK[rd[3:0]];

  always_comb begin
    case (fn)
      mric_pkg::FN_SLLV, mric_pkg::FN_SRLV, mric_pkg::FN_SRAV,
      mric_pkg::FN_SLT, mric_pkg::FN_SLTU: reg_bad = sh != 5'd0;
      mric_pkg::FN_SLL, mric_pkg::FN_SRL, mric_pkg::FN_SRA: reg_bad = rs != 5'd0;
      mric_pkg::FN_MULT, mric_pkg::FN_MULTU, mric_pkg::FN_DIV, mric_pkg::FN_DIVU:
        reg_bad = sh != 5'd0 || rd != 5'd0;
      mric_pkg::FN_JALR: reg_bad = sh != 5'd0 || rt != 5'd0;
      mric_pkg::FN_MFHI, mric_pkg::FN_MFLO:
        reg_bad = sh != 5'd0 || rt != 5'd0 || rs != 5'd0;
      mric_pkg::FN_JR, mric_pkg::FN_MTHI, mric_pkg::FN_MTLO:
        reg_bad = sh != 5'd0 || rt != 5'd0 || rd != 5'd0;
      mric_pkg::FN_SYSCALL, mric_pkg::FN_BREAK: reg_bad = 1'b0;
      default: reg_bad = !(fn inside {[mric_pkg::FN_ADD:mric_pkg::FN_NOR]})
                         || sh != 5'd0;
    endcase
  end

  always_comb begin
    code = op;
    opv  = 32'd0;
    cls  = mric_pkg::CLS_LEGAL;
    case (op[5:3])
      mric_pkg::GRP_BRANCH: begin
        if (op == mric_pkg::OP_SPECIAL) begin
          if (reg_bad) begin
            cls = mric_pkg::CLS_REG;
          end else begin
            code = (word_i == '0) ? mric_pkg::MN_NOP : fn;
            if (fn == mric_pkg::FN_SYSCALL || fn == mric_pkg::FN_BREAK) begin
              opv = {12'd0, word_i[25:6]};
            end
          end
        end else if (op == mric_pkg::OP_REGIMM) begin
          code = {1'b0, rt};
          opv  = boff;
          if (!(rt == mric_pkg::RT_BLTZ || rt == mric_pkg::RT_BGEZ ||
                rt == mric_pkg::RT_BLTZAL || rt == mric_pkg::RT_BGEZAL)) begin
            cls = mric_pkg::CLS_BRANCH;
          end
        end else if (op == mric_pkg::OP_J || op == mric_pkg::OP_JAL) begin
          opv = {4'd0, word_i[25:0], 2'b00};
        end else if (op == mric_pkg::OP_BEQ || op == mric_pkg::OP_BNE || rt == 5'd0) begin
          opv = boff;
        end else begin
          cls = mric_pkg::CLS_BRANCH;
        end
      end
      mric_pkg::GRP_IMM: begin
        if (op <= mric_pkg::OP_SLTIU) begin
          opv = sext;
        end else if (op <= mric_pkg::OP_XORI || rs == 5'd0) begin
          opv = zext;
        end else begin
          cls = mric_pkg::CLS_IMM;
        end
      end
      mric_pkg::GRP_UNK: cls = mric_pkg::CLS_UNK;
      mric_pkg::GRP_LOAD, mric_pkg::GRP_STORE: begin
        opv = sext;
        if (!mric_pkg::LS_VALID_MASK[op]) begin
          cls = mric_pkg::CLS_LS;
        end
      end
      default: begin
        if (op == mric_pkg::OP_COP0) begin
          cls = mric_pkg::CLS_COP;
          case (rs)
            mric_pkg::RS_CO: begin
              if (rt == 5'd0 && rd == 5'd0 && sh == 5'd0) begin
                cls = mric_pkg::CLS_LEGAL;
                case (fn)
                  mric_pkg::CO_RFE: code = mric_pkg::MN_RFE;
                  mric_pkg::CO_TLBR, mric_pkg::CO_TLBWI, mric_pkg::CO_TLBWR,
                  mric_pkg::CO_TLBP: code = fn;
                  mric_pkg::CO_WAIT: code = mric_pkg::MN_WAIT;
                  default: cls = mric_pkg::CLS_COP;
                endcase
              end
            end
            mric_pkg::RS_BC: begin
              opv = boff;
              if (rt == 5'd0) begin
                code = mric_pkg::MN_BC0F;
                cls  = mric_pkg::CLS_LEGAL;
              end else if (rt == 5'd1) begin
                code = mric_pkg::MN_BC0T;
                cls  = mric_pkg::CLS_LEGAL;
              end
            end
            mric_pkg::RS_MF: begin
              if (cp0_valid && sh == 5'd0 && fn == 6'd0) begin
                code = mric_pkg::MN_MFC0;
                cls  = mric_pkg::CLS_LEGAL;
              end
            end
            mric_pkg::RS_MT: begin
              if (cp0_valid && sh == 5'd0 && fn == 6'd0) begin
                code = mric_pkg::MN_MTC0;
                cls  = mric_pkg::CLS_LEGAL;
              end else if (rd == mric_pkg::RD_CONTEXT) begin
                code = mric_pkg::MN_TLBCLR;
                cls  = mric_pkg::CLS_LEGAL;
              end
            end
            default: cls = mric_pkg::CLS_COP;
          endcase
        end else begin
          cls = op[2] ? mric_pkg::CLS_R4K : mric_pkg::CLS_COP;
        end
      end
    endcase
  end

  always_comb begin
    result_o.mnemonic_code      = (cls == mric_pkg::CLS_LEGAL) ? code : 6'd0;
    result_o.illegal_class      = cls;
    result_o.dest_register      = rd;
    result_o.source_register    = rs;
    result_o.target_register    = rt;
    result_o.shift_amount       = sh;
    result_o.operand_value      = (cls == mric_pkg::CLS_LEGAL) ? opv : 32'd0;
    result_o.cp0_register       = rd[4] ? mric_pkg::CP0_PRID_IDX
                                        : mric_pkg::cp0_rd_to_idx(rd[3:0]);
    result_o.coprocessor_number = op[1:0];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mips_r3000_instruction_classifier.sv -----
`default_nettype none

// Classifies one MIPS R3000 instruction word per item into a mnemonic code, an
// illegal-instruction class, the raw register fields and a decoded operand. The
// word is captured in an input register, decoded by one layer of field checks and
// captured again in the result register, from which the result is offered on the
// output. One item is accepted every cycle while the output is taken.
// The input side stalls only when both registers hold items and the output is
// stalled. No state is kept between items and there is nothing to configure.
module mips_r3000_instruction_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] instruction_word
  input  logic [mric_pkg::InDataWidth-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [5:0] mnemonic_code, [8:6] illegal_class, [13:9] dest_register,
  // [18:14] source_register, [23:19] target_register, [28:24] shift_amount,
  // [60:29] operand_value, [64:61] cp0_register, [66:65] coprocessor_number,
  // [71:67] zero
  output logic [mric_pkg::OutDataWidth-1:0]   m_axis_tdata
);

  localparam int unsigned ResWidth = $bits(mric_pkg::result_t);

  logic                              in_valid_q;
  logic [mric_pkg::WordWidth-1:0]    in_word_q;
  logic                              out_valid_q;
  mric_pkg::result_t                 res_d;
  mric_pkg::result_t                 res_q;
  logic                              out_ready;
  logic                              in_ready;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;

  mric_decode u_decode (
    .word_i   (in_word_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata[mric_pkg::WordWidth-1:0];
    end
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(mric_pkg::OutDataWidth - ResWidth){1'b0}}, res_q};

endmodule

`default_nettype wire
